// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and disabled by reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsf assertion failed");

// next-cycle implication
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsf assertion failed");

`endif

// ===== design/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// types, codes and helpers of the line substring filter
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_LEN_W    = 5;
    localparam int CFG_PAT_BYTES = 16;
    localparam int CNT_W        = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY   = 3'd5;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic             result_kind;
        logic [CNT_W-1:0] line_number;
        logic             line_selected;
        logic [CNT_W-1:0] selected_count;
        logic             any_selected;
        logic             last_result;
    } t_out_item;

    typedef struct packed {
        logic [1:0] push_cnt;
        logic       pop;
    } t_queue_ctl;

    function automatic t_byte fold(input t_byte c, input logic en);
        t_byte r;
        r = c;
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== design/lsf_channels.sv =====
// ----------------------------------------------------------------------------
// lsf_channels
// valid/ready channel interfaces for text input, results and register writes
// ----------------------------------------------------------------------------
interface lsf_text_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface lsf_result_if;
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic [lsf_pkg::CNT_W-1:0] line_number;
    logic                     line_selected;
    logic [lsf_pkg::CNT_W-1:0] selected_count;
    logic                     any_selected;
    logic                     last_result;

    modport source (output valid, output result_kind, output line_number,
                    output line_selected, output selected_count, output any_selected,
                    output last_result, input ready);
    modport sink   (input valid, input result_kind, input line_number,
                    input line_selected, input selected_count, input any_selected,
                    input last_result, output ready);
endinterface

interface lsf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lsf_pkg::CFG_IDX_W-1:0]  index;
    logic [lsf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/lsf_window_match.sv =====
// ----------------------------------------------------------------------------
// lsf_window_match
// parallel compare of the byte window against the configured pattern
// ----------------------------------------------------------------------------
module lsf_window_match #(
    parameter int PATTERN_MAX = 16,
    parameter int LEN_W       = 5
) (
    input  lsf_pkg::t_byte                      i_window [PATTERN_MAX],
    input  logic [LEN_W-1:0]                    i_fill,
    input  logic [LEN_W-1:0]                    i_eff_len,
    input  logic [2*lsf_pkg::CFG_DATA_W-1:0]    i_pattern,
    input  logic                                i_ignore_case,
    output logic                                o_match
);
    import lsf_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    t_byte            pat [PATTERN_MAX];
    logic [LEN_W-1:0] pidx [PATTERN_MAX];
    logic             all_ok;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
        if (g < CFG_PAT_BYTES) begin : g_cfg
            assign pat[g] = i_pattern[8*g +: 8];
        end else begin : g_zero
            assign pat[g] = '0;
        end
    end

    always_comb begin
        all_ok = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            pidx[j] = i_eff_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < i_eff_len) begin
                if (fold(i_window[j], i_ignore_case) !=
                    fold(pat[pidx[j][IDX_W-1:0]], i_ignore_case)) begin
                    all_ok = 1'b0;
                end
            end
        end
        o_match = all_ok && (i_eff_len <= i_fill);
    end

endmodule

// ===== design/lsf_out_queue.sv =====
// ----------------------------------------------------------------------------
// lsf_out_queue
// two-entry result queue, takes up to two results in one cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsf_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsf_pkg::t_queue_ctl i_ctl,
    input  lsf_pkg::t_out_item  i_item_a,
    input  lsf_pkg::t_out_item  i_item_b,
    output lsf_pkg::t_out_item  o_head,
    output logic [1:0]          o_count
);
    import lsf_pkg::*;

    t_out_item  r_slot0;
    t_out_item  r_slot1;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [1:0] rem;

    always_comb begin
        rem     = r_count - {1'b0, i_ctl.pop};
        n_count = rem + i_ctl.push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_cnt != 2'd0) begin
            r_slot0 <= i_item_a;
        end else if (i_ctl.pop) begin
            r_slot0 <= r_slot1;
        end
        if (i_ctl.push_cnt == 2'd2) begin
            r_slot1 <= i_item_b;
        end
    end

    assign o_head  = r_slot0;
    assign o_count = r_count;

    `LSF_ASSERT_NOW(a_push_room, i_clk, i_rst_n, i_ctl.push_cnt != 2'd0, rem == 2'd0)
    `LSF_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)
    `LSF_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_ctl.pop, r_count != 2'd0)

endmodule

// ===== design/line_substring_filter_unit.sv =====
// ----------------------------------------------------------------------------
// line_substring_filter_unit
// fixed-string line filter: splits a byte stream into lines and reports
// which hold the pattern (xor invert) unless count-only, then a summary
// ----------------------------------------------------------------------------
//  port       dir   transaction
//  i_text     in    one text byte or an end-of-stream marker
//  o_result   out   one line decision or one end-of-stream summary
//  i_cfg      in    one register write, index and 64-bit data
//
//  one text transaction per cycle if ready; results one per cycle if ready
//  a byte is taken while the two-entry result queue has room for two results
//  i_text.ready follows o_result.ready when one result is still waiting
//  synchronous reset clears counters, line state, registers and the queue
//  register writes are always taken, one per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_substring_filter_unit #(
    parameter int PATTERN_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsf_text_if.sink          i_text,
    lsf_result_if.source      o_result,
    lsf_cfg_if.sink           i_cfg
);
    import lsf_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
    localparam logic [CMP_W-1:0] PMAX_C = CMP_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] FILL_MAX = LEN_W'(PATTERN_MAX);

    logic [CFG_DATA_W-1:0] r_pattern_low;
    logic [CFG_DATA_W-1:0] r_pattern_high;
    logic [CFG_LEN_W-1:0]  r_pattern_length;
    logic                  r_invert;
    logic                  r_ignore_case;
    logic                  r_count_only;

    t_byte            r_recent [PATTERN_MAX];
    t_byte            win      [PATTERN_MAX];
    logic [LEN_W-1:0] r_bytes_in_line;
    logic [LEN_W-1:0] n_bytes_in_line;
    logic             r_line_match;
    logic             r_line_open;
    logic [CNT_W-1:0] r_lines_seen;
    logic [CNT_W-1:0] r_lines_selected;

    logic [CMP_W-1:0] len_ext;
    logic [LEN_W-1:0] eff_len;
    logic             win_match;
    logic             in_fire;
    logic             is_end;
    logic             is_nl;
    logic             is_text;
    logic             finish;
    logic             sel;
    logic             emit_dec;
    logic [CNT_W-1:0] seen_after;
    logic [CNT_W-1:0] selcnt_after;
    t_out_item        dec_item;
    t_out_item        sum_item;
    t_out_item        item_a;
    t_out_item        item_b;
    t_out_item        head;
    t_queue_ctl       q_ctl;
    logic [1:0]       q_count;
    logic             out_valid;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= '0;
            r_invert         <= 1'b0;
            r_ignore_case    <= 1'b0;
            r_count_only     <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN_LOW:  r_pattern_low    <= i_cfg.data;
                REG_PATTERN_HIGH: r_pattern_high   <= i_cfg.data;
                REG_PATTERN_LEN:  r_pattern_length <= i_cfg.data[CFG_LEN_W-1:0];
                REG_INVERT:       r_invert         <= i_cfg.data[0];
                REG_IGNORE_CASE:  r_ignore_case    <= i_cfg.data[0];
                REG_COUNT_ONLY:   r_count_only     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // byte window after the incoming byte
    always_comb begin
        win[0] = i_text.data_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            win[j] = r_recent[j-1];
        end
        len_ext = CMP_W'(r_pattern_length);
        eff_len = (len_ext > PMAX_C) ? LEN_W'(PMAX_C) : LEN_W'(len_ext);
        n_bytes_in_line = (r_bytes_in_line == FILL_MAX) ? r_bytes_in_line
                                                        : r_bytes_in_line + LEN_W'(1);
    end

    lsf_window_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .i_window      (win),
        .i_fill        (n_bytes_in_line),
        .i_eff_len     (eff_len),
        .i_pattern     ({r_pattern_high, r_pattern_low}),
        .i_ignore_case (r_ignore_case),
        .o_match       (win_match)
    );

    // line end and result building
    assign out_valid    = (q_count != 2'd0);
    assign i_text.ready = (q_count == 2'd0) || (q_count == 2'd1 && o_result.ready);
    assign in_fire      = i_text.valid && i_text.ready;

    always_comb begin
        is_end   = (i_text.command == CMD_END);
        is_nl    = !is_end && (i_text.data_byte == CHAR_NEWLINE);
        is_text  = !is_end && !is_nl;
        finish   = is_nl || (is_end && r_line_open);
        sel      = (r_line_match || eff_len == '0) ^ r_invert;
        emit_dec = finish && !r_count_only;

        seen_after   = r_lines_seen;
        selcnt_after = r_lines_selected;
        if (finish) begin
            if (r_lines_seen != CNT_MAX) begin
                seen_after = r_lines_seen + CNT_W'(1);
            end
            if (sel && r_lines_selected != CNT_MAX) begin
                selcnt_after = r_lines_selected + CNT_W'(1);
            end
        end

        dec_item.result_kind    = KIND_DECISION;
        dec_item.line_number    = seen_after;
        dec_item.line_selected  = sel;
        dec_item.selected_count = selcnt_after;
        dec_item.any_selected   = (selcnt_after != '0);
        dec_item.last_result    = is_nl;

        sum_item.result_kind    = KIND_SUMMARY;
        sum_item.line_number    = seen_after;
        sum_item.line_selected  = 1'b0;
        sum_item.selected_count = selcnt_after;
        sum_item.any_selected   = (selcnt_after != '0);
        sum_item.last_result    = 1'b1;

        item_a         = dec_item;
        item_b         = sum_item;
        q_ctl.push_cnt = 2'd0;
        if (in_fire) begin
            if (is_end) begin
                if (emit_dec) begin
                    q_ctl.push_cnt = 2'd2;
                end else begin
                    item_a         = sum_item;
                    q_ctl.push_cnt = 2'd1;
                end
            end else if (emit_dec) begin
                q_ctl.push_cnt = 2'd1;
            end
        end
        q_ctl.pop = out_valid && o_result.ready;
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_line  <= '0;
            r_line_match     <= 1'b0;
            r_line_open      <= 1'b0;
            r_lines_seen     <= '0;
            r_lines_selected <= '0;
        end else if (in_fire) begin
            if (is_text) begin
                r_bytes_in_line <= n_bytes_in_line;
                r_line_open     <= 1'b1;
                if (win_match) begin
                    r_line_match <= 1'b1;
                end
            end else begin
                r_bytes_in_line <= '0;
                r_line_match    <= 1'b0;
                r_line_open     <= 1'b0;
            end
            if (is_end) begin
                r_lines_seen     <= '0;
                r_lines_selected <= '0;
            end else begin
                r_lines_seen     <= seen_after;
                r_lines_selected <= selcnt_after;
            end
        end
    end

    // window bytes beyond the fill count never produce a match
    always_ff @(posedge i_clk) begin
        if (in_fire && is_text) begin
            r_recent <= win;
        end
    end

    lsf_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (q_ctl),
        .i_item_a (item_a),
        .i_item_b (item_b),
        .o_head   (head),
        .o_count  (q_count)
    );

    assign o_result.valid          = out_valid;
    assign o_result.result_kind    = head.result_kind;
    assign o_result.line_number    = head.line_number;
    assign o_result.line_selected  = head.line_selected;
    assign o_result.selected_count = head.selected_count;
    assign o_result.any_selected   = head.any_selected;
    assign o_result.last_result    = head.last_result;

    `LSF_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, in_fire && is_end, r_lines_seen == '0 && r_lines_selected == '0 && !r_line_open)
    `LSF_ASSERT_NOW(a_closed_empty, i_clk, i_rst_n, !r_line_open, r_bytes_in_line == '0 && !r_line_match)
    `LSF_ASSERT_NOW(a_sel_le_seen, i_clk, i_rst_n, 1'b1, r_lines_selected <= r_lines_seen)

endmodule

// ===== tb/line_substring_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_substring_filter_unit_tb
// drives text bytes and end-of-stream markers through the line filter under
// several pattern settings, predicts every line decision and stream summary
// in step with each accepted transaction and checks the results in order,
// with bursty input, a patterned result stall and one long result hold-off
// ----------------------------------------------------------------------------
module line_substring_filter_unit_tb;
    import lsf_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 110;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic  command;
        t_byte data_byte;
    } t_text_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsf_text_if   text_ch ();
    lsf_result_if result_ch ();
    lsf_cfg_if    cfg_ch ();

    line_substring_filter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // filter settings and line state as the block should hold them
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [CFG_LEN_W-1:0]  pat_len;
    logic                  invert_on;
    logic                  fold_on;
    logic                  count_mode;
    t_byte                 win [CFG_PAT_BYTES];
    int                    win_fill;
    logic                  line_hit;
    logic                  line_open;
    logic [CNT_W-1:0]      lines_seen;
    logic [CNT_W-1:0]      lines_picked;

    t_out_item  awaited_reports [$];
    t_text_item text_pending [$];

    int         items_queued   = 0;
    int         items_accepted = 0;
    int         fail_count     = 0;
    int         quiet_cycles   = 0;
    logic       text_taken     = 1'b0;
    logic       result_taken;
    logic       cfg_taken;
    logic       long_hold_req  = 1'b0;
    t_out_item  want;
    t_text_item next_item;
    int         burst_left = 0;
    int         gap_left   = 0;
    int         rx_cycle   = 0;
    int         hold_left  = 0;
    logic       hold_done  = 1'b0;
    t_rx_mode   rx_mode    = RX_ALWAYS;

    function automatic t_byte cased(input t_byte c);
        if (fold_on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic t_byte pattern_at(input int i);
        if (i < 8) begin
            return pat_lo[8*i +: 8];
        end
        if (i < 16) begin
            return pat_hi[8*(i-8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic int active_len();
        return (pat_len > CFG_PAT_BYTES) ? CFG_PAT_BYTES : int'(pat_len);
    endfunction

    function automatic logic window_hit();
        int n;
        n = active_len();
        if (n > win_fill) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (cased(win[n-1-i]) != cased(pattern_at(i))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_line();
        foreach (win[i]) begin
            win[i] = '0;
        end
        win_fill  = 0;
        line_hit  = 1'b0;
        line_open = 1'b0;
    endtask

    task automatic close_line();
        logic pick;
        pick = line_hit || active_len() == 0;
        if (invert_on) begin
            pick = !pick;
        end
        if (lines_seen != CNT_MAX) begin
            lines_seen++;
        end
        if (pick && lines_picked != CNT_MAX) begin
            lines_picked++;
        end
        clear_line();
        if (!count_mode) begin
            awaited_reports.push_back('{result_kind: KIND_DECISION, line_number: lines_seen,
                                        line_selected: pick, selected_count: lines_picked,
                                        any_selected: (lines_picked != '0),
                                        last_result: 1'b0});
        end
    endtask

    task automatic step_filter(input logic cmd, input t_byte b);
        int prior_count;
        prior_count = awaited_reports.size();
        if (cmd == CMD_TEXT) begin
            if (b == CHAR_NEWLINE) begin
                close_line();
            end else begin
                for (int i = CFG_PAT_BYTES - 1; i > 0; i--) begin
                    win[i] = win[i-1];
                end
                win[0] = b;
                if (win_fill < CFG_PAT_BYTES) begin
                    win_fill++;
                end
                line_open = 1'b1;
                if (window_hit()) begin
                    line_hit = 1'b1;
                end
            end
        end else begin
            if (line_open) begin
                close_line();
            end
            awaited_reports.push_back('{result_kind: KIND_SUMMARY, line_number: lines_seen,
                                        line_selected: 1'b0, selected_count: lines_picked,
                                        any_selected: (lines_picked != '0),
                                        last_result: 1'b0});
            clear_line();
            lines_seen   = '0;
            lines_picked = '0;
        end
        if (awaited_reports.size() > prior_count) begin
            awaited_reports[awaited_reports.size()-1].last_result = 1'b1;
        end
    endtask

    // stimulus helpers
    function automatic t_byte likely_byte();
        case ($urandom_range(0, 4))
            0, 1: return CHAR_UPPER_A + t_byte'($urandom_range(0, 1))
                         + ($urandom_range(0, 1) ? CASE_OFFSET : 8'd0);
            2: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte pick_text_byte();
        if ($urandom_range(0, 2) == 0 && active_len() > 0) begin
            return pattern_at($urandom_range(0, active_len() - 1));
        end
        return likely_byte();
    endfunction

    task automatic push_text(input t_byte b);
        text_pending.push_back('{command: CMD_TEXT, data_byte: b});
        items_queued++;
    endtask

    task automatic push_end();
        text_pending.push_back('{command: CMD_END, data_byte: t_byte'($urandom_range(0, 255))});
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    task automatic set_filter(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [CFG_DATA_W-1:0] len, input logic inv,
                              input logic ic, input logic co);
        if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        end
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LEN, len);
        write_reg(REG_INVERT, {{(CFG_DATA_W-1){1'b0}}, inv});
        write_reg(REG_IGNORE_CASE, {{(CFG_DATA_W-1){1'b0}}, ic});
        write_reg(REG_COUNT_ONLY, {{(CFG_DATA_W-1){1'b0}}, co});
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_accepted != items_queued || awaited_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // lines of random content, half of them carrying the pattern, some broken
    task automatic build_stream(input int n, input logic close);
        int    goal;
        int    len;
        int    at;
        logic  with_pat;
        t_byte c;
        goal = items_queued + n;
        while (items_queued < goal) begin
            if ($urandom_range(0, 19) == 0) begin
                push_end();
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(0, 12);
                with_pat = 1'($urandom_range(0, 1));
                at = $urandom_range(0, len);
                for (int i = 0; i <= len; i++) begin
                    if (with_pat && i == at) begin
                        for (int j = 0; j < active_len(); j++) begin
                            c = pattern_at(j);
                            if ($urandom_range(0, 3) == 0
                                && ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                                    || (c >= CHAR_UPPER_A + CASE_OFFSET
                                        && c <= CHAR_UPPER_Z + CASE_OFFSET))) begin
                                c = c ^ CASE_OFFSET;
                            end
                            if ($urandom_range(0, 15) == 0) begin
                                c = likely_byte();
                            end
                            push_text(c);
                        end
                    end
                    if (i < len) begin
                        push_text(pick_text_byte());
                    end
                end
                if ($urandom_range(0, 11) != 0) begin
                    push_text(CHAR_NEWLINE);
                end
            end
        end
        if (close) begin
            push_end();
        end
    endtask

    // sender: bursts of transactions with gaps, valid held until taken
    always @(negedge i_clk) begin
        if (!text_ch.valid || text_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                text_ch.valid <= 1'b0;
            end else if (text_pending.size() > 0) begin
                next_item = text_pending.pop_front();
                text_ch.valid     <= 1'b1;
                text_ch.command   <= next_item.command;
                text_ch.data_byte <= next_item.data_byte;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                text_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold-off
    always @(negedge i_clk) begin
        rx_cycle++;
        if (long_hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_ALWAYS:   result_ch.ready <= 1'b1;
                RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     result_ch.ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    // monitor: predict on accepted transactions, check results in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            text_taken   = text_ch.valid && text_ch.ready;
            result_taken = result_ch.valid && result_ch.ready;
            cfg_taken    = cfg_ch.valid && cfg_ch.ready;
            if (cfg_taken) begin
                case (cfg_ch.index)
                    REG_PATTERN_LOW:  pat_lo     = cfg_ch.data;
                    REG_PATTERN_HIGH: pat_hi     = cfg_ch.data;
                    REG_PATTERN_LEN:  pat_len    = cfg_ch.data[CFG_LEN_W-1:0];
                    REG_INVERT:       invert_on  = cfg_ch.data[0];
                    REG_IGNORE_CASE:  fold_on    = cfg_ch.data[0];
                    REG_COUNT_ONLY:   count_mode = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (text_taken) begin
                step_filter(text_ch.command, text_ch.data_byte);
                items_accepted++;
            end
            if (result_taken) begin
                if (awaited_reports.size() == 0) begin
                    $error("result with nothing awaited");
                    fail_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (result_ch.result_kind !== want.result_kind) begin
                        $error("result_kind expected %0d got %0d",
                               want.result_kind, result_ch.result_kind);
                        fail_count++;
                    end
                    if (result_ch.line_number !== want.line_number) begin
                        $error("line_number expected %0d got %0d",
                               want.line_number, result_ch.line_number);
                        fail_count++;
                    end
                    if (result_ch.line_selected !== want.line_selected) begin
                        $error("line_selected expected %0d got %0d",
                               want.line_selected, result_ch.line_selected);
                        fail_count++;
                    end
                    if (result_ch.selected_count !== want.selected_count) begin
                        $error("selected_count expected %0d got %0d",
                               want.selected_count, result_ch.selected_count);
                        fail_count++;
                    end
                    if (result_ch.any_selected !== want.any_selected) begin
                        $error("any_selected expected %0d got %0d",
                               want.any_selected, result_ch.any_selected);
                        fail_count++;
                    end
                    if (result_ch.last_result !== want.last_result) begin
                        $error("last_result expected %0d got %0d",
                               want.last_result, result_ch.last_result);
                        fail_count++;
                    end
                end
            end
            if (text_taken || result_taken || cfg_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no transaction for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end else begin
            text_taken = 1'b0;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] len;
        text_ch.valid     = 1'b0;
        text_ch.command   = CMD_TEXT;
        text_ch.data_byte = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        pat_lo     = '0;
        pat_hi     = '0;
        pat_len    = '0;
        invert_on  = 1'b0;
        fold_on    = 1'b0;
        count_mode = 1'b0;
        clear_line();
        lines_seen   = '0;
        lines_picked = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern after reset: empty line, unterminated line, summary
        push_text(CHAR_NEWLINE);
        push_text(8'h78);
        push_end();
        wait_drained();

        // byte extremes in text and pattern, then an unterminated non-match
        set_filter(64'h0000_0000_0000_FF00, '0, 64'd2, 1'b0, 1'b0, 1'b0);
        push_text(8'h00);
        push_text(8'hFF);
        push_text(CHAR_NEWLINE);
        push_text(8'hFF);
        push_text(8'h00);
        push_end();
        wait_drained();

        // case folding, inverted decision, count only
        set_filter(64'h0000_0000_0000_6241, '0, 64'd2, 1'b1, 1'b1, 1'b1);
        push_text(8'h61);
        push_text(8'h42);
        push_text(CHAR_NEWLINE);
        push_text(8'h63);
        push_text(CHAR_NEWLINE);
        push_end();
        wait_drained();

        // a newline in the pattern never matches
        set_filter({{(CFG_DATA_W-8){1'b0}}, CHAR_NEWLINE}, '1, 64'd1, 1'b0, 1'b0, 1'b0);
        push_text(8'h7A);
        push_text(CHAR_NEWLINE);
        push_end();
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                set_filter('1, '1, 64'd31, 1'b1, 1'b1, 1'b1);
            end else if (phase == 1) begin
                set_filter('0, '0, '0, 1'b0, 1'b0, 1'b0);
            end else begin
                for (int i = 0; i < 8; i++) begin
                    lo[8*i +: 8] = likely_byte();
                    hi[8*i +: 8] = likely_byte();
                end
                case ($urandom_range(0, 5))
                    0: len = '0;
                    1: len = CFG_DATA_W'(CFG_PAT_BYTES);
                    2: len = CFG_DATA_W'($urandom_range(17, 31));
                    default: len = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                set_filter(lo, hi, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 3) == 0);
            end
            if (phase == 3) begin
                long_hold_req = 1'b1;
            end
            build_stream(PHASE_ITEMS, phase == PHASES - 1 || $urandom_range(0, 2) != 0);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lsf_pkg.sv
design/lsf_channels.sv
design/lsf_window_match.sv
design/lsf_out_queue.sv
design/line_substring_filter_unit.sv
tb/line_substring_filter_unit_tb.sv
